FILE: sv/lrcp_pkg.sv
// Shared constants, register indices, quadrant codes and the CORDIC angle table
// for the lidar ring and column projector. No dependencies.
package lrcp_pkg;

  // Parameter defaults
  localparam int COORD_WIDTH_DEF     = 18;
  localparam int ANGLE_FRAC_BITS_DEF = 20;

  // Fixed field widths
  localparam int RING_W     = 7;
  localparam int COL_W      = 12;
  localparam int QUAD_W     = 3;
  localparam int INTEN_W    = 16;
  localparam int WIDTH_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RING    = 2'd1;

  // Configuration reset values
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd2083;
  localparam logic [RING_W-1:0]  TOP_RING_RESET    = 7'd63;
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_MAX   = 13'd4096;

  // Quadrant codes
  localparam logic [QUAD_W-1:0] QUAD_ORIGIN = 3'd0;
  localparam logic [QUAD_W-1:0] QUAD_1      = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_2      = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_3      = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_4      = 3'd4;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32
  localparam int TURN_TBL_DEPTH = 32;
  localparam logic [31:0] TURN_STEPS [TURN_TBL_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

FILE: sv/lrcp_if.sv
// Valid/ready stream interfaces for lidar points in and projected points out.
// Depends on lrcp_pkg.
interface lrcp_point_if #(
  parameter int COORD_WIDTH = lrcp_pkg::COORD_WIDTH_DEF
) ();
  import lrcp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          start_of_scan;
  logic signed [COORD_WIDTH-1:0] x_pos;
  logic signed [COORD_WIDTH-1:0] y_pos;
  logic signed [COORD_WIDTH-1:0] z_pos;
  logic [INTEN_W-1:0]            intensity_in;

  modport source (output valid, start_of_scan, x_pos, y_pos, z_pos, intensity_in,
                  input ready);
  modport sink   (input valid, start_of_scan, x_pos, y_pos, z_pos, intensity_in,
                  output ready);
endinterface

interface lrcp_result_if #(
  parameter int COORD_WIDTH = lrcp_pkg::COORD_WIDTH_DEF
) ();
  import lrcp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [RING_W-1:0]             ring_index;
  logic [COL_W-1:0]              column_index;
  logic [QUAD_W-1:0]             quadrant_code;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic signed [COORD_WIDTH-1:0] z_out;
  logic [INTEN_W-1:0]            intensity_out;

  modport source (output valid, ring_index, column_index, quadrant_code,
                  x_out, y_out, z_out, intensity_out, input ready);
  modport sink   (input valid, ring_index, column_index, quadrant_code,
                  x_out, y_out, z_out, intensity_out, output ready);
endinterface

FILE: sv/lrcp_front.sv
// Front end: accepts points, classifies quadrant and axis cases, tracks the ring.
// Depends on lrcp_pkg and lrcp_point_if; feeds lrcp_queue.
module lrcp_front #(
  parameter int COORD_WIDTH     = lrcp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = lrcp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int ENTRY_W         = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  lrcp_point_if.sink                 point,
  input  logic [lrcp_pkg::RING_W-1:0] top_ring,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [ENTRY_W-1:0]         push_data
);
  import lrcp_pkg::*;

  typedef struct packed {
    logic [RING_W-1:0]          ring;
    logic [QUAD_W-1:0]          quad;
    logic                       direct;
    logic                       neg;
    logic [ANGLE_FRAC_BITS-1:0] az_preset;
    logic [COORD_WIDTH-1:0]     x;
    logic [COORD_WIDTH-1:0]     y;
    logic [COORD_WIDTH-1:0]     z;
    logic [INTEN_W-1:0]         inten;
  } entry_t;

  localparam logic [ANGLE_FRAC_BITS-1:0] QUARTER_TURN =
    {2'b01, {(ANGLE_FRAC_BITS-2){1'b0}}};
  localparam logic [ANGLE_FRAC_BITS-1:0] HALF_TURN =
    {2'b10, {(ANGLE_FRAC_BITS-2){1'b0}}};
  localparam logic [ANGLE_FRAC_BITS-1:0] THREE_QUARTER_TURN =
    {2'b11, {(ANGLE_FRAC_BITS-2){1'b0}}};

  logic [RING_W-1:0] current_ring;
  logic [QUAD_W-1:0] prev_quad;

  logic              x_zero, y_zero, x_neg, y_neg, x_pos_gt, y_pos_gt;
  logic [QUAD_W-1:0] quad;
  logic [RING_W-1:0] ring_base, ring_next;
  logic [QUAD_W-1:0] prev_base;
  logic              accept;
  entry_t            entry;

  // Sign classification
  always_comb begin
    x_zero   = (point.x_pos == '0);
    y_zero   = (point.y_pos == '0);
    x_neg    = point.x_pos[COORD_WIDTH-1];
    y_neg    = point.y_pos[COORD_WIDTH-1];
    x_pos_gt = !x_neg && !x_zero;
    y_pos_gt = !y_neg && !y_zero;
  end

  // Quadrant decode
  always_comb begin
    if (x_pos_gt && !y_neg) begin
      quad = QUAD_1;
    end else if (!x_pos_gt && y_pos_gt) begin
      quad = QUAD_2;
    end else if (x_neg && !y_pos_gt) begin
      quad = QUAD_3;
    end else if (!x_neg && y_neg) begin
      quad = QUAD_4;
    end else begin
      quad = QUAD_ORIGIN;
    end
  end

  // Ring tracking: wrap from quadrant 4 into quadrant 1 drops one ring, not below 0
  always_comb begin
    ring_base = point.start_of_scan ? top_ring : current_ring;
    prev_base = point.start_of_scan ? QUAD_ORIGIN : prev_quad;
    ring_next = ring_base;
    if (quad == QUAD_1 && prev_base == QUAD_4 && ring_base != '0) begin
      ring_next = ring_base - RING_W'(1);
    end
  end

  // Queue entry; axis points and the origin bypass the rotation
  always_comb begin
    entry.ring      = ring_next;
    entry.quad      = quad;
    entry.direct    = x_zero || y_zero;
    entry.neg       = x_neg;
    entry.az_preset = '0;
    if (y_zero) begin
      entry.az_preset = x_neg ? HALF_TURN : '0;
    end else if (x_zero) begin
      entry.az_preset = y_neg ? THREE_QUARTER_TURN : QUARTER_TURN;
    end
    entry.x     = point.x_pos;
    entry.y     = point.y_pos;
    entry.z     = point.z_pos;
    entry.inten = point.intensity_in;
  end

  assign push_valid  = point.valid;
  assign point.ready = push_ready;
  assign push_data   = ENTRY_W'(entry);
  assign accept      = point.valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_ring <= TOP_RING_RESET;
      prev_quad    <= QUAD_ORIGIN;
    end else if (accept) begin
      current_ring <= ring_next;
      prev_quad    <= quad;
    end
  end

endmodule

FILE: sv/lrcp_queue.sv
// Four-entry FIFO between the front end and the CORDIC back end.
// No package dependencies beyond its width parameter.
module lrcp_queue #(
  parameter int ENTRY_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  logic [ENTRY_W-1:0] push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output logic [ENTRY_W-1:0] pop_data
);
  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  logic [ENTRY_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;
  logic               do_push, do_pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/lrcp_back.sv
// Back end: iterative vectoring CORDIC for the azimuth, column scaling and the
// output register. Depends on lrcp_pkg and lrcp_result_if; fed by lrcp_queue.
module lrcp_back #(
  parameter int COORD_WIDTH     = lrcp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = lrcp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int ENTRY_W         = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic [ENTRY_W-1:0]           pop_data,
  input  logic [lrcp_pkg::WIDTH_W-1:0] image_width,
  lrcp_result_if.source                result
);
  import lrcp_pkg::*;

  typedef struct packed {
    logic [RING_W-1:0]          ring;
    logic [QUAD_W-1:0]          quad;
    logic                       direct;
    logic                       neg;
    logic [ANGLE_FRAC_BITS-1:0] az_preset;
    logic [COORD_WIDTH-1:0]     x;
    logic [COORD_WIDTH-1:0]     y;
    logic [COORD_WIDTH-1:0]     z;
    logic [INTEN_W-1:0]         inten;
  } entry_t;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ROT  = 4'b0010,
    B_MUL  = 4'b0100,
    B_DONE = 4'b1000
  } back_state_t;

  localparam int GUARD_BITS = 61 - COORD_WIDTH;
  localparam int CORDIC_W   = COORD_WIDTH + GUARD_BITS + 3;
  localparam int STAGES     = (ANGLE_FRAC_BITS > 32) ? 32 : ANGLE_FRAC_BITS;
  localparam int STEP_SH    = (ANGLE_FRAC_BITS < 32) ? (32 - ANGLE_FRAC_BITS) : 0;
  localparam int CNT_W      = $clog2(TURN_TBL_DEPTH);
  localparam int PROD_W     = COL_W + ANGLE_FRAC_BITS;
  localparam logic [32:0] STEP_RND = (33'd1 << STEP_SH) >> 1;
  localparam logic [CNT_W-1:0] LAST_STAGE = CNT_W'(STAGES - 1);
  localparam logic [ANGLE_FRAC_BITS-1:0] HALF_TURN =
    {1'b1, {(ANGLE_FRAC_BITS-1){1'b0}}};
  localparam logic [PROD_W-1:0] ROUND_HALF =
    PROD_W'({1'b1, {(ANGLE_FRAC_BITS-1){1'b0}}});

  back_state_t                 state;
  entry_t                      entry;
  logic [RING_W-1:0]           ring_r;
  logic [QUAD_W-1:0]           quad_r;
  logic [COORD_WIDTH-1:0]      x_r, y_r, z_r;
  logic [INTEN_W-1:0]          inten_r;
  logic signed [CORDIC_W-1:0]  px, py;
  logic [ANGLE_FRAC_BITS-1:0]  az;
  logic [CNT_W-1:0]            stage_cnt;
  logic [PROD_W-1:0]           prod;
  logic [COL_W-1:0]            scale;
  logic signed [CORDIC_W-1:0]  x_ext, y_ext, x_load, y_load;
  logic signed [CORDIC_W-1:0]  dx, dy;
  logic [32:0]                 step_wide;
  logic [ANGLE_FRAC_BITS-1:0]  step;
  logic                        py_pos;
  logic [PROD_W-1:0]           col_sum;
  logic                        res_valid;
  logic                        out_free;

  assign entry     = entry_t'(pop_data);
  assign pop_ready = (state == B_IDLE);
  assign out_free  = !res_valid || result.ready;

  // Column scale: width minus one, with width clamped to 1 .. 4096
  always_comb begin
    if (image_width == '0) begin
      scale = '0;
    end else if (image_width > IMAGE_WIDTH_MAX) begin
      scale = COL_W'(IMAGE_WIDTH_MAX - WIDTH_W'(1));
    end else begin
      scale = COL_W'(image_width - WIDTH_W'(1));
    end
  end

  // Load: fold the left half plane over, then scale up by the guard bits
  always_comb begin
    x_ext  = {{(CORDIC_W-COORD_WIDTH){entry.x[COORD_WIDTH-1]}}, entry.x};
    y_ext  = {{(CORDIC_W-COORD_WIDTH){entry.y[COORD_WIDTH-1]}}, entry.y};
    x_load = (entry.neg ? -x_ext : x_ext) <<< GUARD_BITS;
    y_load = (entry.neg ? -y_ext : y_ext) <<< GUARD_BITS;
  end

  // One rotation stage
  always_comb begin
    dx        = py >>> stage_cnt;
    dy        = px >>> stage_cnt;
    step_wide = ({1'b0, TURN_STEPS[stage_cnt]} + STEP_RND) >> STEP_SH;
    step      = step_wide[ANGLE_FRAC_BITS-1:0];
    py_pos    = !py[CORDIC_W-1] && (py != '0);
  end

  assign col_sum = prod + ROUND_HALF;

  // Back-end sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop_valid) state <= entry.direct ? B_MUL : B_ROT;
        end
        B_ROT: begin
          if (stage_cnt == LAST_STAGE) state <= B_MUL;
        end
        B_MUL: begin
          state <= B_DONE;
        end
        B_DONE: begin
          if (out_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (pop_valid) begin
          ring_r    <= entry.ring;
          quad_r    <= entry.quad;
          x_r       <= entry.x;
          y_r       <= entry.y;
          z_r       <= entry.z;
          inten_r   <= entry.inten;
          px        <= x_load;
          py        <= y_load;
          stage_cnt <= '0;
          if (entry.direct) begin
            az <= entry.az_preset;
          end else begin
            az <= entry.neg ? HALF_TURN : '0;
          end
        end
      end
      B_ROT: begin
        if (py_pos) begin
          px <= px + dx;
          py <= py - dy;
          az <= az + step;
        end else begin
          px <= px - dx;
          py <= py + dy;
          az <= az - step;
        end
        stage_cnt <= stage_cnt + CNT_W'(1);
      end
      B_MUL: begin
        prod <= PROD_W'(scale) * PROD_W'(az);
      end
      B_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      result.ring_index    <= ring_r;
      result.column_index  <= col_sum[PROD_W-1:ANGLE_FRAC_BITS];
      result.quadrant_code <= quad_r;
      result.x_out         <= x_r;
      result.y_out         <= y_r;
      result.z_out         <= z_r;
      result.intensity_out <= inten_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == B_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid = res_valid;

endmodule

FILE: sv/lidar_ring_and_column_projector_top.sv
// Top level of the lidar ring and column projector: configuration registers,
// front end, point queue and CORDIC back end. Depends on lrcp_pkg, lrcp_if,
// lrcp_front, lrcp_queue and lrcp_back.
// Channels:
//   point : valid/ready stream of lidar points (start_of_scan, x, y, z,
//           intensity). A beat is taken when valid and ready are high.
//   result: valid/ready stream of projected points (ring, column, quadrant
//           and the copied coordinates and intensity).
//   cfg_* : write port; index 0 is image_width, index 1 is top_ring, other
//           indices are ignored. Write only while the block is idle.
// Timing:
//   A point is queued (four entries) at the edge that takes it. The back end
//   takes one queued point at a time: it loads it, runs one CORDIC stage per
//   cycle, multiplies the angle by the column scale and registers the result,
//   and pops no new point until that result has moved into the output
//   register. Points on an axis or at the origin skip the rotation.
// Reset and stalls: reset empties the queue, drops any result, sets
//   image_width to 2083 and top_ring and the ring to 63. A stalled receiver
//   holds the result; the front keeps filling the queue until it is full,
//   then drops ready.
module lidar_ring_and_column_projector_top #(
  parameter int COORD_WIDTH     = lrcp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = lrcp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  lrcp_point_if.sink                      point,
  lrcp_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [lrcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrcp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lrcp_pkg::*;

  localparam int ENTRY_W = RING_W + QUAD_W + 2 + ANGLE_FRAC_BITS + 3 * COORD_WIDTH + INTEN_W;

  logic [WIDTH_W-1:0] image_width;
  logic [RING_W-1:0]  top_ring;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RESET;
      top_ring    <= TOP_RING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: image_width <= cfg_data[WIDTH_W-1:0];
        REG_TOP_RING:    top_ring    <= cfg_data[RING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lrcp_front #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .point      (point),
    .top_ring   (top_ring),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lrcp_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lrcp_back #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .image_width (image_width),
    .result      (result)
  );

endmodule
